[src/teacb_pkg.sv]
// Shared types, constants and the round mixing function of the TEA cipher block.
package teacb_pkg;

	localparam int WORD_W      = 32;
	localparam int ROUNDS      = 32;
	localparam int NSTAGE      = 2 * ROUNDS;
	localparam int KEY_WORDS   = 4;
	localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	localparam word_t DELTA        = 32'h9e3779b9;
	// Starting sum for decryption, 0xC6EF3720 at 32 rounds
	localparam word_t DEC_SUM_INIT = WORD_W'(ROUNDS) * DELTA;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	typedef struct packed {
		logic  action;
		word_t block_first;
		word_t block_second;
	} in_t;

	typedef struct packed {
		word_t out_first;
		word_t out_second;
	} out_t;

	// Queue entry and pipeline stage contents
	typedef struct packed {
		mode_t mode;
		word_t y;
		word_t z;
	} job_t;

	function automatic word_t mix(input word_t w, input word_t s, input word_t ka,
		input word_t kb);
		mix = ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
	endfunction

endpackage

[src/teacb_front.sv]
// Front end: takes blocks, tags their mode and queues them for the round pipeline.
module teacb_front import teacb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic blk_valid,
	output logic blk_stall,
	input  in_t  blk_data,
	input  logic pop,
	output logic job_valid,
	output job_t job
);

	localparam logic [QPTR_W:0] FULL_CNT = (QPTR_W+1)'(QUEUE_DEPTH);

	job_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	job_t              entry;

	assign blk_stall = (cnt_q == FULL_CNT);
	assign push      = blk_valid && !blk_stall;
	assign job_valid = (cnt_q != '0);
	assign job       = queue_q[rd_ptr_q];

	// Classify the block by its action bit
	always_comb begin
		entry.mode = blk_data.action ? MODE_DEC : MODE_ENC;
		entry.y    = blk_data.block_first;
		entry.z    = blk_data.block_second;
	end

	// Store the entry on a transfer
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/teacb_back.sv]
// Back end: unrolled half-round pipeline that runs the TEA rounds, ending in the result register.
module teacb_back import teacb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  key_t key,
	input  logic job_valid,
	input  job_t job,
	output logic pop,
	output logic res_valid,
	input  logic res_stall,
	output out_t res_data
);

	job_t              stg_s [NSTAGE];
	logic [NSTAGE-1:0] vld_s;
	job_t              nxt   [NSTAGE];
	logic              adv;

	// Whole pipeline moves unless a finished result is held
	assign adv = !vld_s[NSTAGE-1] || !res_stall;
	assign pop = adv && job_valid;

	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		localparam bit    FIRST   = (i % 2) == 0;
		localparam word_t SUM_ENC = WORD_W'(i / 2 + 1) * DELTA;
		localparam word_t SUM_DEC = DEC_SUM_INIT - WORD_W'(i / 2) * DELTA;

		job_t  cur;
		logic  use_k01;
		logic  enc;
		word_t src;
		word_t tgt;
		word_t m;
		word_t upd;

		if (i == 0) begin : g_head
			assign cur = job;
		end else begin : g_body
			assign cur = stg_s[i-1];
		end

		// One half-round: update the first word with keys 0/1 or the second with keys 2/3
		always_comb begin
			enc     = (cur.mode == MODE_ENC);
			use_k01 = (FIRST == enc);
			src     = use_k01 ? cur.z : cur.y;
			tgt     = use_k01 ? cur.y : cur.z;
			m       = use_k01 ? mix(src, enc ? SUM_ENC : SUM_DEC, key[0], key[1])
			                  : mix(src, enc ? SUM_ENC : SUM_DEC, key[2], key[3]);
			upd     = enc ? tgt + m : tgt - m;
			nxt[i].mode = cur.mode;
			nxt[i].y    = use_k01 ? upd : cur.y;
			nxt[i].z    = use_k01 ? cur.z : upd;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NSTAGE; i++) begin
				stg_s[i] <= nxt[i];
			end
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTAGE-2:0], job_valid};
		end
	end

	assign res_valid           = vld_s[NSTAGE-1];
	assign res_data.out_first  = stg_s[NSTAGE-1].y;
	assign res_data.out_second = stg_s[NSTAGE-1].z;

endmodule

[src/tea_block_cipher.sv]
// TEA block cipher top level: key registers, front queue and round pipeline.
// Encrypts or decrypts one 64-bit block per transfer with the 128-bit key in registers
// 0 to 3, using the standard 32 TEA rounds with delta 0x9e3779b9. One block is taken
// every clock cycle unless the queue is full; the rounds are unrolled into 64 pipeline
// stages of one half-round (one mix and one add or subtract) each, and results come out
// in the order the blocks came in. A four-entry queue sits in front of the pipeline;
// while a result is held by res_stall the pipeline freezes and the queue keeps taking
// blocks until it fills. Key writes are meant for an idle block.
module tea_block_cipher import teacb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 blk_valid,
	output logic                 blk_stall,
	input  in_t                  blk_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output out_t                 res_data,
	input  logic                 cfg_we,
	input  logic [KEY_IDX_W-1:0] cfg_index,
	input  word_t                cfg_data
);

	key_t key_q;
	logic job_valid;
	job_t job;
	logic pop;

	// Key register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	teacb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk_data  (blk_data),
		.pop       (pop),
		.job_valid (job_valid),
		.job       (job)
	);

	teacb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key_q),
		.job_valid (job_valid),
		.job       (job),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// The pipeline only takes from a non-empty queue
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> job_valid)
		else $error("pipeline took from an empty queue");

	// A queued job that is not taken stays queued
	a_job_kept: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !pop |=> job_valid)
		else $error("queued job lost");

	// Input is held back only when the queue has work in it
	a_stall_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		blk_stall |-> job_valid)
		else $error("input stalled with empty queue");

endmodule

[tb/sv/tb_tea_block_cipher.sv]
// Self-checking testbench for the TEA block cipher: random traffic, key changes, scoreboard.
`timescale 1ns / 100ps

module tb_tea_block_cipher;
	import teacb_pkg::*;

	localparam word_t TEA_DELTA      = 32'h9e3779b9;
	localparam word_t DEC_SUM_START  = 32'hC6EF3720;
	localparam int    TEA_CYCLES     = 32;
	localparam int    DRAIN_PAD      = 80;
	localparam int    WATCHDOG_LIMIT = 4000;
	localparam int    MAX_REPORTS    = 10;
	localparam int    RANDOM_BATCH   = 167;

	// Predicts each block's cipher output and checks results in order
	class cipher_scoreboard;
		word_t key_words[KEY_WORDS];
		out_t  expected_blocks[$];
		int    mismatch_count;
		int    results_checked;

		function new();
			foreach (key_words[i]) key_words[i] = '0;
			mismatch_count  = 0;
			results_checked = 0;
		endfunction

		function word_t round_f(word_t w, word_t s, word_t ka, word_t kb);
			return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
		endfunction

		function out_t tea_transform(in_t b);
			word_t y;
			word_t z;
			word_t s;
			out_t  r;
			y = b.block_first;
			z = b.block_second;
			if (mode_t'(b.action) == MODE_ENC) begin
				s = '0;
				for (int n = 0; n < TEA_CYCLES; n++) begin
					s = s + TEA_DELTA;
					y = y + round_f(z, s, key_words[0], key_words[1]);
					z = z + round_f(y, s, key_words[2], key_words[3]);
				end
			end else begin
				// undo the cycles in reverse, second word first
				s = DEC_SUM_START;
				for (int n = 0; n < TEA_CYCLES; n++) begin
					z = z - round_f(y, s, key_words[2], key_words[3]);
					y = y - round_f(z, s, key_words[0], key_words[1]);
					s = s - TEA_DELTA;
				end
			end
			r.out_first  = y;
			r.out_second = z;
			return r;
		endfunction

		function void note_block(in_t b);
			expected_blocks.push_back(tea_transform(b));
		endfunction

		function void report(string what, logic [63:0] want, logic [63:0] got);
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS) begin
				$display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_blocks.size() == 0) begin
				report("result with nothing pending", '0, got);
				return;
			end
			want = expected_blocks.pop_front();
			results_checked++;
			if (got.out_first !== want.out_first) begin
				report("out_first", 64'(want.out_first), 64'(got.out_first));
			end
			if (got.out_second !== want.out_second) begin
				report("out_second", 64'(want.out_second), 64'(got.out_second));
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 blk_valid;
	logic                 blk_stall;
	in_t                  blk_data;
	logic                 res_valid;
	logic                 res_stall;
	out_t                 res_data;
	logic                 cfg_we;
	logic [KEY_IDX_W-1:0] cfg_index;
	word_t                cfg_data;

	cipher_scoreboard board;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int blocks_sent    = 0;
	int stuck_cycles   = 0;

	tea_block_cipher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_stall (blk_stall),
		.blk_data  (blk_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Check results, note accepted blocks, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) board.check_result(res_data);
			if (blk_valid && !blk_stall) board.note_block(blk_data);
			if ((res_valid && !res_stall) || (blk_valid && !blk_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic key_t pick_key();
		key_t k;
		for (int i = 0; i < KEY_WORDS; i++) k[i] = pick_word();
		return k;
	endfunction

	// Hold one block on the input until it transfers
	task automatic send_block(input in_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			blk_valid <= 1'b0;
			@(posedge clk);
		end
		blk_valid <= 1'b1;
		blk_data  <= b;
		do @(posedge clk); while (blk_stall);
		blocks_sent++;
	endtask

	task automatic send_both(input word_t w0, input word_t w1);
		in_t b;
		b.block_first  = w0;
		b.block_second = w1;
		b.action       = MODE_ENC;
		send_block(b);
		b.action       = MODE_DEC;
		send_block(b);
	endtask

	// Write all four key words; the block must be idle
	task automatic load_key(input key_t k);
		for (int i = 0; i < KEY_WORDS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= KEY_IDX_W'(i);
			cfg_data  <= k[i];
			@(posedge clk);
			board.key_words[i] = k[i];
		end
		cfg_we <= 1'b0;
	endtask

	// Drop valid and wait until every sent block has come back
	task automatic wait_drained();
		blk_valid <= 1'b0;
		while (board.results_checked < blocks_sent) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Random blocks; an encryption is often followed by decryption of its output
	task automatic run_random(input int count);
		in_t  b;
		out_t prior;
		logic have_prior;
		have_prior = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (have_prior && $urandom_range(3) == 0) begin
				b.action       = MODE_DEC;
				b.block_first  = prior.out_first;
				b.block_second = prior.out_second;
				have_prior     = 1'b0;
			end else begin
				b.action       = 1'($urandom_range(1));
				b.block_first  = pick_word();
				b.block_second = pick_word();
				have_prior     = (b.action == MODE_ENC);
				if (have_prior) prior = board.tea_transform(b);
			end
			send_block(b);
		end
	endtask

	initial begin
		board = new();
		arst_n    <= 1'b0;
		blk_valid <= 1'b0;
		blk_data  <= '0;
		res_stall <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks with the key left at reset
		send_both(32'h0000_0000, 32'h0000_0000);
		send_both(32'hffff_ffff, 32'hffff_ffff);
		send_both(32'h0000_0000, 32'hffff_ffff);
		send_both(32'hffff_ffff, 32'h0000_0000);
		send_both(32'h8000_0000, 32'h0000_0001);
		send_both(32'haaaa_aaaa, 32'h5555_5555);
		wait_drained();

		// all-ones key
		load_key('1);
		send_both(32'h0000_0000, 32'h0000_0000);
		send_both(32'hffff_ffff, 32'hffff_ffff);
		wait_drained();

		// mixed key pattern
		load_key({32'h7654_3210, 32'hfedc_ba98, 32'h89ab_cdef, 32'h0123_4567});
		send_both(32'h0123_4567, 32'h89ab_cdef);
		wait_drained();

		// sender idles lightly, receiver heavily; then swapped; then no idling
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 27;
					recv_stall_pct <= 71;
				end
				1: begin
					send_idle_pct  = 71;
					recv_stall_pct <= 27;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 0;
				end
			endcase
			for (int sub = 0; sub < 2; sub++) begin
				load_key(pick_key());
				run_random(RANDOM_BATCH);
				wait_drained();
			end
		end

		if (board.mismatch_count == 0 && board.expected_blocks.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
